// File: sv/lpbev_pkg.sv
// Package for the lidar point to bird's-eye pixel writer.
// Holds fixed-point constants, register indexes, the pixel beat type and the hue ramp.
// No dependencies.
`default_nettype none

package lpbev_pkg;

    // Fractional bits of coordinate*scale (2^-10 m times Q8.8)
    localparam int FRAC_BITS = 18;
    // Width of the exact cell difference before truncation
    localparam int DIFF_W = 42;
    // Width of coordinate*scale products
    localparam int PROD_W = 41;
    // Intensity clamp
    localparam logic [7:0] MAX_INTENSITY = 8'd80;
    // Pixel coordinate width on the ports
    localparam int PIX_W = 10;

    // Register indexes
    localparam logic [0:0] REG_CELLS_PER_METER = 1'b0;
    localparam logic [0:0] REG_GRAY_OFFSET     = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
    } pixel_t;

    function automatic logic [6:0] clamp_intensity(input logic [7:0] v);
        logic [7:0] c;
        c = (v > MAX_INTENSITY) ? MAX_INTENSITY : v;
        return c[6:0];
    endfunction

    // Blue-green-red hue ramp for a clamped intensity 0..80
    function automatic logic [23:0] hue(input logic [6:0] i);
        logic [9:0] nine_i;
        logic [9:0] lo;
        logic [9:0] hi;
        logic [9:0] b;
        logic [9:0] g;
        logic [9:0] r;
        nine_i = 10'(i) * 10'd9;
        lo     = nine_i >> 1;
        hi     = (nine_i + 10'd1) >> 1;
        if (i < 7'd40)
        begin
            b = 10'd255 - hi;
            g = 10'd75 + lo;
            r = 10'd75;
        end
        else
        begin
            b = 10'd75;
            g = 10'd435 - hi;
            r = lo - 10'd105;
        end
        return {b[7:0], g[7:0], r[7:0]};
    endfunction

endpackage

`default_nettype wire

// File: sv/lidar_point_to_bev_pixel.sv
// Lidar point to bird's-eye canvas pixel writer, top level.
// An accepted beat passes the product, difference and cell stages and the
// output register before its first pixel write. Throughput: one item per
// cycle; a two-write item holds the pipe (busy high) while its first write
// leaves. Reset: rst_n asynchronous, active low; clears valids and restores
// registers (cells_per_meter 8533, gray_offset 128). Results cannot be stalled.
`default_nettype none

module lidar_point_to_bev_pixel
    import lpbev_pkg::*;
#(
    parameter int CANVAS_SIZE = 600
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration write port
    input  wire logic               wr_en,
    input  wire logic [0:0]         wr_index,
    input  wire logic [15:0]        wr_data,
    // command side
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               dual_pair,
    input  wire logic signed [23:0] first_x,
    input  wire logic signed [23:0] first_y,
    input  wire logic [7:0]         first_intensity,
    input  wire logic [23:0]        first_distance,
    input  wire logic signed [23:0] second_x,
    input  wire logic signed [23:0] second_y,
    input  wire logic [7:0]         second_intensity,
    input  wire logic [23:0]        second_distance,
    // result side
    output logic                    done,
    output logic [PIX_W-1:0]        pixel_column,
    output logic [PIX_W-1:0]        pixel_row,
    output logic [7:0]              blue,
    output logic [7:0]              green,
    output logic [7:0]              red,
    output logic                    last_of_run
);

    localparam logic signed [DIFF_W-1:0] CENTER_FX =
        DIFF_W'(CANVAS_SIZE / 2) <<< FRAC_BITS;
    localparam logic signed [DIFF_W-1:0] LOW_LIM  = -(DIFF_W'(1) <<< FRAC_BITS);
    localparam logic signed [DIFF_W-1:0] HIGH_LIM = DIFF_W'(CANVAS_SIZE) <<< FRAC_BITS;

    // configuration registers
    logic [15:0] cpm_reg;
    logic [7:0]  gray_offset_reg;

    // stage 1: products
    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] s1_fx_reg, s1_fy_reg, s1_sx_reg, s1_sy_reg;
    logic [6:0]               s1_fint_reg, s1_sint_reg;
    logic                     s1_second_reg;

    // stage 2: differences
    logic                     s2_valid_reg;
    logic signed [DIFF_W-1:0] s2_fx_reg, s2_fy_reg, s2_sx_reg, s2_sy_reg;
    logic [6:0]               s2_fint_reg, s2_sint_reg;
    logic                     s2_second_reg;

    // stage 3: cells and colours
    logic   s3_valid_reg;
    logic   s3_fok_reg, s3_sok_reg;
    pixel_t s3_first_reg, s3_second_reg;

    // output stage
    logic   phase_reg, phase_next;
    logic   done_reg, done_next;
    logic   last_reg, last_next;
    pixel_t out_reg, out_next;

    logic   stall;
    logic   accept;

    logic signed [16:0] scale_s;
    assign scale_s = $signed({1'b0, cpm_reg});

    // hold the whole pipe while the first of two writes leaves
    assign stall  = s3_valid_reg && s3_fok_reg && s3_sok_reg && !phase_reg;
    assign busy   = stall;
    assign accept = start && !busy;

    function automatic logic cell_ok(input logic signed [DIFF_W-1:0] v);
        return (v > LOW_LIM) && (v < HIGH_LIM);
    endfunction

    function automatic logic [PIX_W-1:0] cell_of(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? '0 : v[FRAC_BITS+PIX_W-1:FRAC_BITS];
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpm_reg         <= 16'd8533;
            gray_offset_reg <= 8'd128;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_CELLS_PER_METER: cpm_reg         <= wr_data;
                REG_GRAY_OFFSET:     gray_offset_reg <= wr_data[7:0];
                default:             ;
            endcase
        end
    end

    // valid bits travel with the beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            // multiply coordinates by scale
            s1_fx_reg     <= first_x * scale_s;
            s1_fy_reg     <= first_y * scale_s;
            s1_sx_reg     <= second_x * scale_s;
            s1_sy_reg     <= second_y * scale_s;
            s1_fint_reg   <= clamp_intensity(first_intensity);
            s1_sint_reg   <= clamp_intensity(second_intensity);
            s1_second_reg <= dual_pair && (second_distance < first_distance);

            // subtract from the scaled centre
            s2_fx_reg     <= CENTER_FX - DIFF_W'(s1_fx_reg);
            s2_fy_reg     <= CENTER_FX - DIFF_W'(s1_fy_reg);
            s2_sx_reg     <= CENTER_FX - DIFF_W'(s1_sx_reg);
            s2_sy_reg     <= CENTER_FX - DIFF_W'(s1_sy_reg);
            s2_fint_reg   <= s1_fint_reg;
            s2_sint_reg   <= s1_sint_reg;
            s2_second_reg <= s1_second_reg;

            // bound-check, truncate to cells, colour
            s3_fok_reg <= cell_ok(s2_fx_reg) && cell_ok(s2_fy_reg);
            s3_sok_reg <= s2_second_reg && cell_ok(s2_sx_reg) && cell_ok(s2_sy_reg);
            s3_first_reg.col <= cell_of(s2_fy_reg);
            s3_first_reg.row <= cell_of(s2_fx_reg);
            {s3_first_reg.blue, s3_first_reg.green, s3_first_reg.red} <=
                hue(s2_fint_reg);
            s3_second_reg.col   <= cell_of(s2_sy_reg);
            s3_second_reg.row   <= cell_of(s2_sx_reg);
            s3_second_reg.blue  <= {1'b0, s2_sint_reg} + gray_offset_reg;
            s3_second_reg.green <= {1'b0, s2_sint_reg} + gray_offset_reg;
            s3_second_reg.red   <= {1'b0, s2_sint_reg} + gray_offset_reg;
        end
    end

    // pick the write to issue this cycle
    always_comb
    begin
        phase_next = 1'b0;
        done_next  = 1'b0;
        last_next  = 1'b0;
        out_next   = s3_first_reg;
        if (s3_valid_reg)
        begin
            if (phase_reg)
            begin
                done_next = 1'b1;
                last_next = 1'b1;
                out_next  = s3_second_reg;
            end
            else if (s3_fok_reg)
            begin
                done_next  = 1'b1;
                last_next  = !s3_sok_reg;
                phase_next = s3_sok_reg;
            end
            else if (s3_sok_reg)
            begin
                done_next = 1'b1;
                last_next = 1'b1;
                out_next  = s3_second_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    assign done         = done_reg;
    assign last_of_run  = last_reg;
    assign pixel_column = out_reg.col;
    assign pixel_row    = out_reg.row;
    assign blue         = out_reg.blue;
    assign green        = out_reg.green;
    assign red          = out_reg.red;

endmodule

`default_nettype wire

// File: bench/lidar_point_to_bev_pixel_tb.sv
// Testbench for lidar_point_to_bev_pixel: directed and random point beats,
// checked against an in-bench predictor of the canvas pixel writes.
// Depends on lpbev_pkg and the lidar_point_to_bev_pixel top level.
`timescale 1ns / 1ps

module lidar_point_to_bev_pixel_tb;
    import lpbev_pkg::*;

    localparam int          CANVAS     = 600;
    localparam int          CLK_HALF   = 5;
    localparam int          DRAIN_WAIT = 10;
    localparam int          MAX_CYCLES = 300000;
    localparam int          MAX_SHOWN  = 10;
    localparam logic [15:0] RESET_SCALE = 16'd8533;
    localparam logic [7:0]  RESET_GRAY  = 8'd128;

    // One command beat: a point or a dual-return pair
    typedef struct packed {
        logic               dual;
        logic signed [23:0] fx;
        logic signed [23:0] fy;
        logic [7:0]         fi;
        logic [23:0]        fd;
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic [7:0]         si;
        logic [23:0]        sd;
    } lidar_item_t;

    // One pixel write on the result side
    typedef struct packed {
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
        logic [7:0]       b;
        logic [7:0]       g;
        logic [7:0]       r;
        logic             last;
    } pixel_write_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               wr_en = 1'b0;
    logic [0:0]         wr_index = REG_CELLS_PER_METER;
    logic [15:0]        wr_data = '0;
    logic               start = 1'b0;
    logic               busy;
    logic               dual_pair = 1'b0;
    logic signed [23:0] first_x = '0;
    logic signed [23:0] first_y = '0;
    logic [7:0]         first_intensity = '0;
    logic [23:0]        first_distance = '0;
    logic signed [23:0] second_x = '0;
    logic signed [23:0] second_y = '0;
    logic [7:0]         second_intensity = '0;
    logic [23:0]        second_distance = '0;
    logic               done;
    logic [PIX_W-1:0]   pixel_column;
    logic [PIX_W-1:0]   pixel_row;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic               last_of_run;

    // Shadow copies of the block's registers
    logic [15:0]        scale_q = RESET_SCALE;
    logic [7:0]         gray_bias = RESET_GRAY;

    pixel_write_t       pending_writes[$];
    int                 fail_count = 0;
    int                 cycle_count = 0;

    lidar_point_to_bev_pixel #(
        .CANVAS_SIZE (CANVAS)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .wr_en            (wr_en),
        .wr_index         (wr_index),
        .wr_data          (wr_data),
        .start            (start),
        .busy             (busy),
        .dual_pair        (dual_pair),
        .first_x          (first_x),
        .first_y          (first_y),
        .first_intensity  (first_intensity),
        .first_distance   (first_distance),
        .second_x         (second_x),
        .second_y         (second_y),
        .second_intensity (second_intensity),
        .second_distance  (second_distance),
        .done             (done),
        .pixel_column     (pixel_column),
        .pixel_row        (pixel_row),
        .blue             (blue),
        .green            (green),
        .red              (red),
        .last_of_run      (last_of_run)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Map one coordinate to a canvas cell; 0 when the point falls off the canvas
    function automatic bit coord_to_cell(input logic signed [23:0] pos,
                                         output logic [PIX_W-1:0] cell_idx);
        longint offset;
        longint whole;
        offset = (longint'(CANVAS / 2) <<< FRAC_BITS)
                 - longint'(pos) * longint'({1'b0, scale_q});
        cell_idx = '0;
        if (offset < 0)
        begin
            // anything in (-1, 0) truncates to cell 0
            if (((-offset) >>> FRAC_BITS) != 0)
                return 1'b0;
            return 1'b1;
        end
        whole = offset >>> FRAC_BITS;
        if (whole >= CANVAS)
            return 1'b0;
        cell_idx = PIX_W'(whole);
        return 1'b1;
    endfunction

    function automatic int unsigned clamped_level(input logic [7:0] v);
        return (v > 8'd80) ? 80 : int'(v);
    endfunction

    // Blue-green-red ramp over clamped intensity
    function automatic logic [23:0] ramp_colour(input int unsigned level);
        int unsigned half_dn;
        int unsigned half_up;
        half_dn = (9 * level) / 2;
        half_up = (9 * level + 1) / 2;
        if (level < 40)
            return {8'(255 - half_up), 8'(75 + half_dn), 8'd75};
        return {8'd75, 8'(435 - half_up), 8'(half_dn - 105)};
    endfunction

    // Queue the pixel writes one beat should cause
    task automatic predict_pixel_writes(input lidar_item_t it);
        pixel_write_t wr;
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
        logic [7:0] shade;
        int produced;
        produced = 0;
        if (coord_to_cell(it.fy, col) && coord_to_cell(it.fx, row))
        begin
            wr.col = col;
            wr.row = row;
            {wr.b, wr.g, wr.r} = ramp_colour(clamped_level(it.fi));
            wr.last = 1'b0;
            pending_writes.push_back(wr);
            produced++;
        end
        if (it.dual && (it.sd < it.fd)
            && coord_to_cell(it.sy, col) && coord_to_cell(it.sx, row))
        begin
            shade = 8'(clamped_level(it.si) + int'(gray_bias));
            wr.col = col;
            wr.row = row;
            wr.b = shade;
            wr.g = shade;
            wr.r = shade;
            wr.last = 1'b0;
            pending_writes.push_back(wr);
            produced++;
        end
        if (produced > 0)
            pending_writes[pending_writes.size() - 1].last = 1'b1;
    endtask

    // Check each pixel write against the oldest expectation
    always @(posedge clk)
    begin
        pixel_write_t got;
        pixel_write_t want;
        if (rst_n && done)
        begin
            got = '{pixel_column, pixel_row, blue, green, red, last_of_run};
            if (pending_writes.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("unexpected write: col %0d row %0d bgr %0d/%0d/%0d last %0b",
                             got.col, got.row, got.b, got.g, got.r, got.last);
            end
            else
            begin
                want = pending_writes.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display({"mismatch: want col %0d row %0d bgr %0d/%0d/%0d last %0b,",
                                  " got col %0d row %0d bgr %0d/%0d/%0d last %0b"},
                                 want.col, want.row, want.b, want.g, want.r, want.last,
                                 got.col, got.row, got.b, got.g, got.r, got.last);
                end
            end
        end
    end

    // Present one beat and hold it until accepted; a nonzero gap then drops start and idles
    task automatic send_point(input lidar_item_t it, input int unsigned gap);
        start            <= 1'b1;
        dual_pair        <= it.dual;
        first_x          <= it.fx;
        first_y          <= it.fy;
        first_intensity  <= it.fi;
        first_distance   <= it.fd;
        second_x         <= it.sx;
        second_y         <= it.sy;
        second_intensity <= it.si;
        second_distance  <= it.sd;
        do
            @(posedge clk);
        while (busy);
        predict_pixel_writes(it);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and wait for the pipe to empty, allowing for beats with no write
    task automatic settle();
        start <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_register(input logic [0:0] index, input logic [15:0] value);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        if (index == REG_CELLS_PER_METER)
            scale_q = value;
        else
            gray_bias = value[7:0];
        @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] scale, input logic [7:0] bias);
        settle();
        write_register(REG_CELLS_PER_METER, scale);
        write_register(REG_GRAY_OFFSET, {8'd0, bias});
    endtask

    function automatic lidar_item_t make_item(
        input logic dual,
        input int fx, input int fy, input int fi, input int fd,
        input int sx, input int sy, input int si, input int sd);
        lidar_item_t it;
        it.dual = dual;
        it.fx = 24'(fx);
        it.fy = 24'(fy);
        it.fi = 8'(fi);
        it.fd = 24'(fd);
        it.sx = 24'(sx);
        it.sy = 24'(sy);
        it.si = 8'(si);
        it.sd = 24'(sd);
        return it;
    endfunction

    // Mostly short gaps, a few long ones, none in a burst
    function automatic int unsigned pick_gap(input bit burst);
        int unsigned roll;
        if (burst)
            return 0;
        roll = $urandom_range(99, 0);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Coordinate near the canvas for the current scale, a little beyond the edges
    function automatic logic [23:0] near_coord();
        int unsigned span;
        span = (scale_q == 0) ? 8388607 : (310 * 262144) / int'(scale_q);
        if (span > 8388607)
            span = 8388607;
        return 24'(int'($urandom_range(2 * span, 0)) - int'(span));
    endfunction

    function automatic lidar_item_t random_point();
        lidar_item_t it;
        logic [191:0] noise;
        int unsigned roll;
        roll = $urandom_range(9, 0);
        // noise: every field fully random
        if (roll == 0)
        begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            it = noise[$bits(lidar_item_t)-1:0];
            return it;
        end
        it.dual = ($urandom_range(9, 0) < 6);
        it.fx = near_coord();
        it.fy = near_coord();
        it.sx = near_coord();
        it.sy = near_coord();
        it.fi = $urandom_range(1, 0) ? 8'($urandom_range(90, 0)) : 8'($urandom);
        it.si = $urandom_range(1, 0) ? 8'($urandom_range(90, 0)) : 8'($urandom);
        it.fd = 24'($urandom);
        case ($urandom_range(3, 0))
            0, 1: it.sd = (it.fd == 0) ? 24'd0 : 24'($urandom_range(int'(it.fd) - 1, 0));
            2: it.sd = it.fd;
            default: it.sd = 24'($urandom);
        endcase
        return it;
    endfunction

    // Hue breakpoints, intensity clamp, pair ordering and far-off points at reset scale
    task automatic test_reset_defaults();
        send_point(make_item(0, 0, 0, 0, 500, 0, 0, 0, 0), 0);
        send_point(make_item(0, 1000, -1000, 39, 500, 0, 0, 0, 0), 1);
        send_point(make_item(0, -2000, 3000, 40, 500, 0, 0, 0, 0), 0);
        send_point(make_item(0, 5000, 5000, 80, 500, 0, 0, 0, 0), 2);
        send_point(make_item(0, 100, 100, 255, 500, 0, 0, 0, 0), 0);
        send_point(make_item(0, 8388607, -8388608, 81, 0,
                             -1, -1, 255, 16777215), 0);
        send_point(make_item(1, 200, -300, 10, 9000, -700, 800, 255, 4000), 0);
        send_point(make_item(1, 200, -300, 60, 9000, -700, 800, 12, 9000), 3);
        send_point(make_item(1, 200, -300, 60, 9000, -700, 800, 12, 9001), 0);
        send_point(make_item(1, -8388608, 0, 20, 9000, 700, -800, 40, 100), 0);
        send_point(make_item(1, -8388608, 8388607, 20, 9000, 8388607, 0, 40, 100), 1);
        send_point(make_item(1, 0, 0, 5, 0, 10, 10, 5, 0), 0);
        send_point(make_item(1, 0, 0, 5, 16777215, 10, 10, 81, 0), 0);
        settle();
    endtask

    // One cell per metre: exact canvas edges and the fraction below cell 0
    task automatic test_canvas_edges();
        set_config(16'd256, RESET_GRAY);
        send_point(make_item(0, 300 * 1024, 0, 30, 1, 0, 0, 0, 0), 0);
        send_point(make_item(0, 300 * 1024 + 1, 0, 30, 1, 0, 0, 0, 0), 0);
        send_point(make_item(0, 301 * 1024, 0, 30, 1, 0, 0, 0, 0), 0);
        send_point(make_item(0, -299 * 1024 - 1, 0, 30, 1, 0, 0, 0, 0), 2);
        send_point(make_item(0, -300 * 1024, 0, 30, 1, 0, 0, 0, 0), 0);
        send_point(make_item(1, 0, 300 * 1024 + 1, 30, 9, 0, -299 * 1024, 70, 3), 0);
        send_point(make_item(1, 0, -300 * 1024, 30, 9, 0, 301 * 1024 - 1, 70, 3), 0);
        settle();
    endtask

    // Zero scale sends every point to the centre cell
    task automatic test_zero_scale();
        set_config(16'd0, RESET_GRAY);
        send_point(make_item(1, -8388608, 8388607, 45, 50, 8388607, -8388608, 7, 49), 0);
        send_point(make_item(0, 123456, -654321, 0, 50, 0, 0, 0, 0), 0);
        settle();
    endtask

    // Gray value at both ends of the offset range
    task automatic test_gray_offset();
        set_config(RESET_SCALE, 8'd175);
        send_point(make_item(1, 0, 0, 3, 100, 500, 500, 80, 99), 0);
        set_config(RESET_SCALE, 8'd0);
        send_point(make_item(1, 0, 0, 3, 100, 500, 500, 0, 99), 0);
        settle();
    endtask

    // Random traffic over several register settings, with bursts of back-to-back beats
    task automatic test_random_traffic();
        logic [15:0] scales[6];
        logic [7:0]  biases[6];
        bit burst;
        scales = '{RESET_SCALE, 16'd65535, 16'd1, 16'($urandom), 16'd256, 16'd12000};
        biases = '{RESET_GRAY, 8'd175, 8'd0, 8'($urandom_range(175, 0)), 8'd64, 8'd175};
        for (int p = 0; p < 6; p++)
        begin
            set_config(scales[p], biases[p]);
            burst = 1'b0;
            for (int n = 0; n < 72; n++)
            begin
                if (n % 18 == 0)
                    burst = ($urandom_range(2, 0) == 0);
                send_point(random_point(), pick_gap(burst));
            end
        end
        settle();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_canvas_edges();
        test_zero_scale();
        test_gray_offset();
        test_random_traffic();
        // anything still queued never arrived
        if (pending_writes.size() != 0)
        begin
            fail_count += pending_writes.size();
            $display("%0d expected pixel writes never arrived", pending_writes.size());
        end
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
sv/lpbev_pkg.sv
sv/lidar_point_to_bev_pixel.sv
bench/lidar_point_to_bev_pixel_tb.sv
